// ----- rtl/beat_tracking_dp_forward_top_assert.svh -----
// Assertion macros shared by the beat tracker RTL.
`ifndef BEAT_TRACKING_DP_FORWARD_TOP_ASSERT_SVH
`define BEAT_TRACKING_DP_FORWARD_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/btdp_pkg.sv -----
// Package: widths, register codes, log2 table and shared types for the beat tracker.
package btdp_pkg;

    // Period limit and history ring geometry
    localparam int MAX_FPB    = 128;
    localparam int HIST_DEPTH = 2 * MAX_FPB;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int LAG_W      = $clog2(HIST_DEPTH + 1);

    // Field widths
    localparam int FPB_W     = 8;
    localparam int TIGHT_W   = 16;
    localparam int IN_W      = 24;
    localparam int CUM_W     = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    // Fixed-point widths of the penalty datapath
    localparam int FRAC_W = 24;
    localparam int LOG_W  = FRAC_W + $clog2(HIST_AW + 1);
    localparam int S_W    = 2 * LOG_W - FRAC_W;
    localparam int PEN_W  = S_W + TIGHT_W - 20;
    localparam int CAND_W = ((CUM_W > PEN_W) ? CUM_W : PEN_W) + 1;
    localparam int SUM_W  = CAND_W + 1;

    localparam logic [FRAC_W-1:0] LN2_Q24 = 24'd11629080;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FPB    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

    // Register reset values
    localparam logic [FPB_W-1:0]   FPB_RST    = 8'd43;
    localparam logic [TIGHT_W-1:0] TIGHT_RST  = 16'd25600;
    localparam logic [IN_W-1:0]    THRESH_RST = 24'd0;
    localparam logic [FPB_W-1:0]   FPB_MIN    = 8'd2;

    // log2(x) in Q.24: repeated squaring of a Q1.30 mantissa, truncating
    function automatic logic [LOG_W-1:0] f_log2_q24(input int unsigned x);
        int unsigned       e;
        longint unsigned   m;
        logic [FRAC_W-1:0] frac;
        e    = 0;
        frac = '0;
        for (int b = 0; b < 31; b++) begin
            if ((x >> (b + 1)) != 0) begin
                e = unsigned'(b + 1);
            end
        end
        m = 64'(x) << (30 - e);
        for (int k = 0; k < FRAC_W; k++) begin
            m    = (m * m) >> 30;
            frac = {frac[FRAC_W-2:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return {e[LOG_W-FRAC_W-1:0], frac};
    endfunction

    // Entry i holds log2(i + 1)
    typedef logic [LOG_W-1:0] t_log_tbl [HIST_DEPTH];

    function automatic t_log_tbl f_build_log_tbl();
        t_log_tbl tbl;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            tbl[i] = f_log2_q24(unsigned'(i + 1));
        end
        return tbl;
    endfunction

    localparam t_log_tbl LOG2_TBL = f_build_log_tbl();

    // One candidate lag entering the penalty pipeline
    typedef struct packed {
        logic             vld;
        logic [LAG_W-1:0] lag;
        logic [LOG_W-1:0] log_gap;
    } t_cand_req;

    // Scored candidate leaving the penalty pipeline
    typedef struct packed {
        logic                     vld;
        logic [LAG_W-1:0]         lag;
        logic signed [CAND_W-1:0] score;
    } t_cand;

endpackage

// ----- rtl/btdp_if.sv -----
// Valid/ready channel interfaces for onset input and beat score output.
interface btdp_in_if;
    import btdp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] local_score;

    modport source (output valid, output local_score, input ready);
    modport sink   (input valid, input local_score, output ready);
endinterface

interface btdp_out_if;
    import btdp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CUM_W-1:0] cumulative_score;
    logic                    link_valid;
    logic [LAG_W-1:0]        predecessor_lag;

    modport source (output valid, output cumulative_score, output link_valid,
                    output predecessor_lag, input ready);
    modport sink   (input valid, input cumulative_score, input link_valid,
                    input predecessor_lag, output ready);
endinterface

// ----- rtl/btdp_penalty.sv -----
// Four-stage pipeline: log-lag penalty of one candidate and its penalized score.
module btdp_penalty (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  btdp_pkg::t_cand_req               i_req,
    input  logic signed [btdp_pkg::CUM_W-1:0] i_hist,
    input  logic [btdp_pkg::TIGHT_W-1:0]      i_tightness,
    output btdp_pkg::t_cand                   o_cand,
    output logic                              o_busy
);
    import btdp_pkg::*;

    localparam int PA_W = LOG_W + FRAC_W;
    localparam int PS_W = 2 * LOG_W;
    localparam int PT_W = S_W + TIGHT_W;

    logic [PA_W-1:0] w_prod_a;
    logic [PS_W-1:0] w_prod_s;
    logic [PT_W-1:0] w_prod_t;

    // stage A: natural-log distance, stage B: square, stage C: weight, stage D: score
    logic                    r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic [LAG_W-1:0]        r_a_lag, r_b_lag, r_c_lag, r_d_lag;
    logic signed [CUM_W-1:0] r_a_hist, r_b_hist, r_c_hist;
    logic [LOG_W-1:0]        r_a;
    logic [S_W-1:0]          r_s;
    logic [PEN_W-1:0]        r_pen;
    logic signed [CAND_W-1:0] r_score;

    // round-half-up products
    assign w_prod_a = PA_W'(i_req.log_gap) * PA_W'(LN2_Q24) + (PA_W'(1) << (FRAC_W - 1));
    assign w_prod_s = PS_W'(r_a) * PS_W'(r_a) + (PS_W'(1) << (FRAC_W - 1));
    assign w_prod_t = PT_W'(r_s) * PT_W'(i_tightness) + (PT_W'(1) << 19);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_req.vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_a      <= w_prod_a[PA_W-1:FRAC_W];
        r_a_lag  <= i_req.lag;
        r_a_hist <= i_hist;

        r_s      <= w_prod_s[PS_W-1:FRAC_W];
        r_b_lag  <= r_a_lag;
        r_b_hist <= r_a_hist;

        r_pen    <= w_prod_t[PT_W-1:20];
        r_c_lag  <= r_b_lag;
        r_c_hist <= r_b_hist;

        r_score  <= $signed({{(CAND_W - CUM_W){r_c_hist[CUM_W-1]}}, r_c_hist})
                  - $signed({{(CAND_W - PEN_W){1'b0}}, r_pen});
        r_d_lag  <= r_c_lag;
    end

    assign o_cand.vld   = r_d_vld;
    assign o_cand.lag   = r_d_lag;
    assign o_cand.score = r_score;
    assign o_busy       = r_a_vld | r_b_vld | r_c_vld | r_d_vld;

endmodule

// ----- rtl/beat_tracking_dp_forward_top.sv -----
// Beat tracker forward pass: one cumulative score and backlink per onset frame.
//
// Usage: each transfer on i_in carries one frame's local onset score (Q11.12).
// For every frame one transfer leaves on o_out: the saturated cumulative score
// (Q27.12), a link flag and the lag back to the best predecessor frame.
// Registers (period, tightness, first-beat threshold) are to be written on the
// i_cfg_* port only while no frame is in flight; the block does not enforce it.
// Flow: frames are processed one at a time. A frame searches N lags, where N
// is at most 2*MAX_FPB - MAX_FPB/2 + 1 (193 at MAX_FPB = 128); the history
// memory port reads one candidate a cycle into a four-stage penalty pipeline,
// and the result is registered on o_out once the pipeline has drained.
// A frame with no candidate skips the search and goes straight to draining.
// The block takes no new frame until the previous one has finished.
// i_in.ready is high while the block is idle; the next frame may be taken
// while the previous result still waits in the output register.
// Stalls: if o_out.ready stays low, the finished frame waits in its final
// state and no further history write happens until the output slot frees.
// Reset: clears pointers and frame count, sets the first-beat flag, loads default
// registers; the history memory itself is not cleared, old entries are never
// read because the search never reaches past the frames seen.
module beat_tracking_dp_forward_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [btdp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [btdp_pkg::CFG_W-1:0]          i_cfg_wdata,
    btdp_in_if.sink                             i_in,
    btdp_out_if.source                          o_out
);
    import btdp_pkg::*;

`include "beat_tracking_dp_forward_top_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Configuration registers
    logic [FPB_W-1:0]       r_fpb;
    logic [TIGHT_W-1:0]     r_tight;
    logic signed [IN_W-1:0] r_thresh;

    // Control state
    t_state                 r_state;
    logic [HIST_AW-1:0]     r_wptr;
    logic [LAG_W-1:0]       r_frames_seen;
    logic                   r_bfb;
    logic                   r_found;
    logic                   r_out_vld;
    t_cand_req              r_s1;

    // Per-frame working registers
    logic signed [IN_W-1:0]   r_local;
    logic [LAG_W-1:0]         r_lag;
    logic [LAG_W-1:0]         r_lag_end;
    logic [LOG_W-1:0]         r_log_fpb;
    logic signed [CAND_W-1:0] r_best;
    logic [LAG_W-1:0]         r_best_lag;

    // Output registers
    logic signed [CUM_W-1:0] r_out_cum;
    logic                    r_out_link;
    logic [LAG_W-1:0]        r_out_lag;

    // History memory
    logic signed [CUM_W-1:0] r_hist [HIST_DEPTH];
    logic signed [CUM_W-1:0] r_rd_data;

    logic [FPB_W-1:0]        w_fpb_c;
    logic [FPB_W-1:0]        w_half8;
    logic [LAG_W-1:0]        w_half;
    logic [LAG_W-1:0]        w_twice;
    logic [LAG_W-1:0]        w_end;
    logic [LAG_W-1:0]        w_lag_m1;
    logic [LOG_W-1:0]        w_log_lag;
    logic [LOG_W-1:0]        w_dist;
    logic [HIST_AW-1:0]      w_rd_addr;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [CUM_W-1:0] w_cum;
    logic                    w_link_open;
    logic                    w_link;
    logic                    w_fin_fire;
    logic                    w_pen_busy;
    t_cand                   w_cand;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpb    <= FPB_RST;
            r_tight  <= TIGHT_RST;
            r_thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FPB:    r_fpb    <= i_cfg_wdata[FPB_W-1:0];
                CFG_TIGHT:  r_tight  <= i_cfg_wdata[TIGHT_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg_wdata[IN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamped period, round-half-even half period and search end
    always_comb begin
        if (r_fpb < FPB_MIN) begin
            w_fpb_c = FPB_MIN;
        end else if (r_fpb > FPB_W'(MAX_FPB)) begin
            w_fpb_c = FPB_W'(MAX_FPB);
        end else begin
            w_fpb_c = r_fpb;
        end
        w_half8 = (w_fpb_c >> 1) + FPB_W'(w_fpb_c[0] & w_fpb_c[1]);
        w_half  = LAG_W'(w_half8);
        w_twice = LAG_W'(w_fpb_c) << 1;
        w_end   = (w_twice < r_frames_seen) ? w_twice : r_frames_seen;
    end

    // Log distance of the lag being issued
    assign w_lag_m1  = r_lag - LAG_W'(1);
    assign w_log_lag = LOG2_TBL[w_lag_m1[HIST_AW-1:0]];
    assign w_dist    = (w_log_lag >= r_log_fpb) ? (w_log_lag - r_log_fpb)
                                                : (r_log_fpb - w_log_lag);
    assign w_rd_addr = r_wptr - r_lag[HIST_AW-1:0];

    // Cumulative score with saturation to the output width
    always_comb begin
        if (r_found) begin
            w_sum = $signed({{(SUM_W - IN_W){r_local[IN_W-1]}}, r_local})
                  + $signed({r_best[CAND_W-1], r_best});
        end else begin
            w_sum = $signed({{(SUM_W - IN_W){r_local[IN_W-1]}}, r_local});
        end
        if ((&w_sum[SUM_W-1:CUM_W-1]) || !(|w_sum[SUM_W-1:CUM_W-1])) begin
            w_cum = w_sum[CUM_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_cum = {1'b1, {(CUM_W - 1){1'b0}}};
        end else begin
            w_cum = {1'b0, {(CUM_W - 1){1'b1}}};
        end
    end

    // Links open once a frame reaches the threshold
    assign w_link_open = !(r_bfb && (r_local < r_thresh));
    assign w_link      = w_link_open && r_found;
    assign w_fin_fire  = (r_state == S_FINISH) && (!r_out_vld || o_out.ready);

    btdp_penalty u_penalty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (r_s1),
        .i_hist      (r_rd_data),
        .i_tightness (r_tight),
        .o_cand      (w_cand),
        .o_busy      (w_pen_busy)
    );

    // History ring: one write per finished frame, one registered read per lag
    always_ff @(posedge i_clk) begin
        if (w_fin_fire) begin
            r_hist[r_wptr] <= w_cum;
        end
        r_rd_data <= r_hist[w_rd_addr];
    end

    // Sequencer, best-candidate tracking and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_wptr        <= '0;
            r_frames_seen <= '0;
            r_bfb         <= 1'b1;
            r_found       <= 1'b0;
            r_out_vld     <= 1'b0;
            r_s1.vld      <= 1'b0;
        end else begin
            // one lag issued per search cycle; output slot holds until its transfer
            r_s1.vld  <= (r_state == S_SEARCH);
            r_out_vld <= w_fin_fire || (r_out_vld && !o_out.ready);

            // running best, shortest lag kept on ties
            if (w_cand.vld && (!r_found || (w_cand.score > r_best))) begin
                r_best     <= w_cand.score;
                r_best_lag <= w_cand.lag;
                r_found    <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_local   <= i_in.local_score;
                        r_lag     <= w_half;
                        r_lag_end <= w_end;
                        r_log_fpb <= LOG2_TBL[HIST_AW'(w_fpb_c - FPB_W'(1))];
                        r_found   <= 1'b0;
                        r_state   <= (w_half > w_end) ? S_DRAIN : S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_s1.lag     <= r_lag;
                    r_s1.log_gap <= w_dist;
                    if (r_lag == r_lag_end) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_lag <= r_lag + LAG_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_s1.vld && !w_pen_busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_fin_fire) begin
                        r_out_cum  <= w_cum;
                        r_out_link <= w_link;
                        r_out_lag  <= w_link ? r_best_lag : '0;
                        r_wptr     <= r_wptr + HIST_AW'(1);
                        if (r_frames_seen != LAG_W'(HIST_DEPTH)) begin
                            r_frames_seen <= r_frames_seen + LAG_W'(1);
                        end
                        if (w_link_open) begin
                            r_bfb <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_vld;
    assign o_out.cumulative_score = r_out_cum;
    assign o_out.link_valid       = r_out_link;
    assign o_out.predecessor_lag  = r_out_lag;

    // A new frame is only taken once the penalty pipeline has emptied
    `BTDP_ASSERT_NOW(a_idle_pipe_empty, i_clk, i_rst_n, i_in.ready, !r_s1.vld && !w_pen_busy, "frame accepted with candidates in flight")

    // Issued lags stay inside the searched window
    `BTDP_ASSERT_NOW(a_lag_window, i_clk, i_rst_n, r_state == S_SEARCH, (r_lag <= r_lag_end) && (r_lag != '0) && (r_lag_end <= r_frames_seen), "lag outside search window")

    // Frame count never passes the ring depth
    `BTDP_ASSERT_NOW(a_frames_sat, i_clk, i_rst_n, 1'b1, r_frames_seen <= LAG_W'(HIST_DEPTH), "frame count beyond ring depth")

    // A finished frame always lands in the output register
    `BTDP_ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, w_fin_fire, r_out_vld && (r_state == S_IDLE), "finished frame not presented")

    // No link means no lag
    `BTDP_ASSERT_NOW(a_nolink_lag, i_clk, i_rst_n, r_out_vld && !r_out_link, r_out_lag == '0, "lag reported without link")

endmodule
